/* hw/rtl/keyed_dwell_time_tracker_assert.svh */
// assertion macros for the keyed dwell-time tracker
// expects i_clk and i_rst_n in the including module
`ifndef KEYED_DWELL_TIME_TRACKER_ASSERT_SVH
`define KEYED_DWELL_TIME_TRACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KDTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kdtt same-cycle check failed");

// next-cycle implication, checked out of reset
`define KDTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kdtt next-cycle check failed");

`endif

/* hw/rtl/kdtt_pkg.sv */
// shared types and constants for the keyed dwell-time tracker
// no dependencies
`default_nettype none

package kdtt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int TIME_BITS_DEF     = 32;
    localparam int ID_W              = 16;
    localparam int NOW_W             = 32;
    localparam int DWELL_W           = 32;

    typedef enum logic [2:0] {
        KIND_ENTRY   = 3'd0,
        KIND_EXIT    = 3'd1,
        KIND_DWELL   = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_FULL    = 3'd4
    } t_rec_kind;

    // event request
    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  vehicle_id;
        logic [NOW_W-1:0] now_ticks;
    } t_req;

    // one result record
    typedef struct packed {
        t_rec_kind          record_kind;
        logic [ID_W-1:0]    record_id;
        logic [DWELL_W-1:0] dwell_ticks;
        logic               last;
    } t_rec;

    // record handed from the controller to the output stage
    typedef struct packed {
        logic strobe;
        t_rec rec;
    } t_emit;

endpackage

`default_nettype wire

/* hw/rtl/kdtt_mem.sv */
// slot table storage: one write port, one read port, registered read data
// depends on nothing
`default_nettype none

module kdtt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 49
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/kdtt_ctrl.sv */
// scan controller: clears the table, scans slots, writes back and builds records
// depends on kdtt_pkg; drives the ports of kdtt_mem
`default_nettype none

module kdtt_ctrl #(
    parameter int TABLE_ENTRIES = kdtt_pkg::TABLE_ENTRIES_DEF,
    parameter int TIME_BITS     = kdtt_pkg::TIME_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire kdtt_pkg::t_req                   i_req,
    output logic                                  o_busy,
    output kdtt_pkg::t_emit                       o_emit,
    output logic                                  o_mem_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0]      o_mem_waddr,
    output logic [kdtt_pkg::ID_W+TIME_BITS:0]     o_mem_wdata,
    output logic                                  o_mem_re,
    output logic [$clog2(TABLE_ENTRIES)-1:0]      o_mem_raddr,
    input  wire logic [kdtt_pkg::ID_W+TIME_BITS:0] i_mem_rdata
);

    import kdtt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = 1 + ID_W + TIME_BITS;
    localparam int WW = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_WAIT   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_EMIT2  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic                   r_rd_vld, n_rd_vld;
    logic                   r_hit, n_hit;
    logic                   r_free, n_free;
    logic [AW-1:0]          r_rd_idx;
    t_req                   r_req;
    logic [AW-1:0]          r_hit_idx;
    logic [TIME_BITS-1:0]   r_hit_time;
    logic [AW-1:0]          r_free_idx;
    logic [DWELL_W-1:0]     r_dwell;

    logic                   ptr_last;
    logic                   rd_valid;
    logic [ID_W-1:0]        rd_id;
    logic [TIME_BITS-1:0]   rd_time;
    logic                   hit_take;
    logic                   free_take;
    logic [WW-1:0]          now_wide;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   dwell_t;
    logic [WW-1:0]          dwell_wide;

    // unpack the slot read back from the table
    assign rd_valid = i_mem_rdata[EW-1];
    assign rd_id    = i_mem_rdata[EW-2 -: ID_W];
    assign rd_time  = i_mem_rdata[TIME_BITS-1:0];

    // time arithmetic modulo 2^TIME_BITS
    assign now_wide   = WW'(r_req.now_ticks);
    assign now_t      = now_wide[TIME_BITS-1:0];
    assign dwell_t    = now_t - r_hit_time;
    assign dwell_wide = WW'(dwell_t);

    assign ptr_last  = (r_ptr == AW'(TABLE_ENTRIES - 1));
    assign hit_take  = r_rd_vld && rd_valid && (rd_id == r_req.vehicle_id) && !r_hit;
    assign free_take = r_rd_vld && !rd_valid && !r_free;

    assign o_busy      = (r_state != S_IDLE);
    assign o_mem_raddr = r_ptr;

    // next-state and table access
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_rd_vld    = 1'b0;
        n_hit       = r_hit | hit_take;
        n_free      = r_free | free_take;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_emit      = '0;
        unique case (r_state)
            S_CLEAR: begin
                // clearing pass: one slot per cycle, valid bit low
                o_mem_we = 1'b1;
                if (ptr_last) begin
                    n_state = S_IDLE;
                    n_ptr   = '0;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                    n_ptr   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                end
            end
            S_SCAN: begin
                o_mem_re = 1'b1;
                n_rd_vld = 1'b1;
                if (ptr_last) begin
                    n_state = S_WAIT;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_WAIT: begin
                // last slot is compared this cycle
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_emit.strobe          = 1'b1;
                o_emit.rec.record_id   = r_req.vehicle_id;
                o_emit.rec.dwell_ticks = '0;
                o_emit.rec.last        = 1'b1;
                n_state                = S_IDLE;
                if (!r_req.kind) begin
                    // arrival: refresh a known slot or claim the lowest free one
                    if (r_hit || r_free) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_hit ? r_hit_idx : r_free_idx;
                        o_mem_wdata = {1'b1, r_req.vehicle_id, now_t};
                        o_emit.rec.record_kind = KIND_ENTRY;
                    end else begin
                        o_emit.rec.record_kind = KIND_FULL;
                    end
                end else if (r_hit) begin
                    // departure of a known id: free the slot, exit then dwell
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_hit_idx;
                    o_emit.rec.record_kind = KIND_EXIT;
                    o_emit.rec.last        = 1'b0;
                    n_state                = S_EMIT2;
                end else begin
                    o_emit.rec.record_kind = KIND_UNKNOWN;
                end
            end
            S_EMIT2: begin
                o_emit.strobe          = 1'b1;
                o_emit.rec.record_kind = KIND_DWELL;
                o_emit.rec.record_id   = r_req.vehicle_id;
                o_emit.rec.dwell_ticks = r_dwell;
                o_emit.rec.last        = 1'b1;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
                n_ptr   = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_rd_vld <= n_rd_vld;
            r_hit    <= n_hit;
            r_free   <= n_free;
        end
    end

    // request and scan results
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ptr;
        if (r_state == S_IDLE && i_start) begin
            r_req <= i_req;
        end
        if (hit_take) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_time <= rd_time;
        end
        if (free_take) begin
            r_free_idx <= r_rd_idx;
        end
        if (r_state == S_DECIDE) begin
            r_dwell <= dwell_wide[DWELL_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/keyed_dwell_time_tracker.sv */
// top level of the keyed dwell-time tracker: table memory, scan controller, record register
// depends on kdtt_pkg, kdtt_mem, kdtt_ctrl and keyed_dwell_time_tracker_assert.svh
`default_nettype none

// Each event request is taken when start is high and busy is low. The block then
// reads every slot of the table memory once through its single read port, so an
// event keeps busy high through the scan, wait and decide states, and also through
// the second emit state for a departure of a known vehicle. Records appear on o_rec
// for exactly one cycle with o_strobe high and cannot be held off; they leave
// through an output register, so the final record of an event shows in the first
// cycle that busy is low again. A known departure gives an exit record and then a
// dwell record in the next cycle, with last marking the final record of the event.
// After reset a clearing pass over every slot empties the table while busy stays
// high.
module keyed_dwell_time_tracker #(
    parameter int TABLE_ENTRIES = kdtt_pkg::TABLE_ENTRIES_DEF,
    parameter int TIME_BITS     = kdtt_pkg::TIME_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire kdtt_pkg::t_req i_req,
    output logic                busy,
    output logic                o_strobe,
    output kdtt_pkg::t_rec      o_rec
);

    import kdtt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = 1 + ID_W + TIME_BITS;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;
    t_emit         emit;
    logic          r_strobe;
    t_rec          r_rec;

    // slot table
    kdtt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // scan and write-back sequencer
    kdtt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TIME_BITS     (TIME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_emit      (emit),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // output record register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= emit.strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.strobe) begin
            r_rec <= emit.rec;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rec    = r_rec;

    // checks on the sequencing of requests and records
    `include "keyed_dwell_time_tracker_assert.svh"

    `KDTT_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
    `KDTT_ASSERT_NEXT(a_exit_then_dwell, o_strobe && !o_rec.last,
        o_strobe && o_rec.last && (o_rec.record_kind == KIND_DWELL))
    `KDTT_ASSERT_NOW(a_dwell_only_on_dwell, o_strobe && (o_rec.record_kind != KIND_DWELL),
        o_rec.dwell_ticks == '0)

endmodule

`default_nettype wire
